/* design/blsu_pkg.sv */
// ----------------------------------------------------------------------------
// blsu_pkg
// Shared types and constants for the line stepper: screen bounds, the
// request kind and the queued item that passes from front to back.
// ----------------------------------------------------------------------------
package blsu_pkg;

	localparam int unsigned SCREEN_WIDTH  = 240;
	localparam int unsigned SCREEN_HEIGHT = 320;

	localparam int unsigned QUEUE_AW    = 2;
	localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned ERR_W   = 18;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_STEP = 1'b1
	} blsu_req_t;

	// One classified request; load fields are don't-care on a step
	typedef struct packed {
		blsu_req_t           req;
		logic [COORD_W-1:0]  start_x;
		logic [COORD_W-1:0]  start_y;
		logic [COORD_W-1:0]  end_x;
		logic [COORD_W-1:0]  end_y;
		logic [COORD_W-1:0]  span_x;
		logic [COORD_W-1:0]  span_y;
		logic                step_x_neg;
		logic                step_y_neg;
		logic [ERR_W-1:0]    error_term;
		logic [15:0]         color;
	} blsu_item_t;

endpackage

/* design/bresenham_line_stepper_unit.sv */
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// All-octant Bresenham line engine with stream input and pixel output.
// ----------------------------------------------------------------------------
// A load request (tuser = 0) sets up a line from start to end point with a
// color and emits nothing; each step request (tuser = 1) emits the current
// pixel and advances, the end pixel carrying tlast, after which the engine
// is idle and further steps are dropped. With the output taken each cycle
// the unit sustains one request and one pixel per clock. A step's item is
// written into a queue entry by the input transfer and its pixel into the
// output register from the queue head, so each pixel passes through both
// registers before it is presented. A four-entry queue sits between input
// decode and the stepper, so input keeps flowing while the output is
// stalled until the queue fills.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // start_x, start_y, end_x, end_y, color
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // pixel_x, pixel_y, pixel_color
	output logic        m_axis_tuser,  // visible
	output logic        m_axis_tlast
);
	import blsu_pkg::*;

	blsu_item_t push_item;
	blsu_item_t head_item;
	logic       push;
	logic       full;
	logic       head_valid;
	logic       pop;

	blsu_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.queue_full    (full),
		.push          (push),
		.item          (push_item)
	);

	blsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	blsu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

/* design/blsu_front.sv */
// ----------------------------------------------------------------------------
// blsu_front
// Input side: decodes the request kind and, for a load, works out spans,
// step directions and the initial error term before queuing the item.
// ----------------------------------------------------------------------------
module blsu_front (
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [79:0]         s_axis_tdata,  // start_x, start_y, end_x, end_y, color
	input  logic                s_axis_tuser,  // req_type
	input  logic                queue_full,
	output logic                push,
	output blsu_pkg::blsu_item_t item
);
	import blsu_pkg::*;

	logic [COORD_W-1:0] x0, y0, x1, y1;

	assign x0 = s_axis_tdata[15:0];
	assign y0 = s_axis_tdata[31:16];
	assign x1 = s_axis_tdata[47:32];
	assign y1 = s_axis_tdata[63:48];

	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;

	always_comb begin
		item            = '0;
		item.req        = blsu_req_t'(s_axis_tuser);
		item.start_x    = x0;
		item.start_y    = y0;
		item.end_x      = x1;
		item.end_y      = y1;
		item.span_x     = (x1 > x0) ? (x1 - x0) : (x0 - x1);
		item.span_y     = (y1 > y0) ? (y1 - y0) : (y0 - y1);
		// equal coordinates count as a negative step
		item.step_x_neg = !(x0 < x1);
		item.step_y_neg = !(y0 < y1);
		item.error_term = {2'b00, item.span_x} - {2'b00, item.span_y};
		item.color      = s_axis_tdata[79:64];
	end

endmodule

/* design/blsu_queue.sv */
// ----------------------------------------------------------------------------
// blsu_queue
// Short register queue between the front and the back so each side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module blsu_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  blsu_pkg::blsu_item_t push_item,
	output logic                 full,
	output logic                 head_valid,
	output blsu_pkg::blsu_item_t head_item,
	input  logic                 pop
);
	import blsu_pkg::*;

	blsu_item_t            slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/blsu_back.sv */
// ----------------------------------------------------------------------------
// blsu_back
// Line state and the Bresenham update: takes queued requests, emits one
// pixel per step into an output register and advances the error term.
// ----------------------------------------------------------------------------
module blsu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  blsu_pkg::blsu_item_t head_item,
	output logic                 pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [47:0]          m_axis_tdata,  // pixel_x, pixel_y, pixel_color
	output logic                 m_axis_tuser,  // visible
	output logic                 m_axis_tlast
);
	import blsu_pkg::*;

	logic [COORD_W-1:0] pos_x_q, pos_y_q, target_x_q, target_y_q;
	logic [COORD_W-1:0] span_x_q, span_y_q;
	logic               step_x_neg_q, step_y_neg_q;
	logic [ERR_W-1:0]   error_term_q;
	logic [15:0]        line_color_q;
	logic               active_q;

	logic               out_valid_q;
	logic [47:0]        out_data_q;
	logic               out_visible_q;
	logic               out_last_q;

	logic               is_load;
	logic               out_space;
	logic               emit;
	logic               at_end;
	logic               visible;
	logic signed [ERR_W:0] e2;
	logic signed [ERR_W:0] neg_span_y;
	logic signed [ERR_W:0] pos_span_x;
	logic signed [ERR_W:0] err_next;
	logic               take_x;
	logic               take_y;
	logic [COORD_W-1:0] next_x, next_y;

	assign is_load   = (head_item.req == REQ_LOAD);
	assign out_space = !out_valid_q || m_axis_tready;
	assign emit      = head_valid && !is_load && active_q && out_space;
	// a step while idle is dropped without output
	assign pop       = head_valid && (is_load || !active_q || out_space);

	assign at_end  = (pos_x_q == target_x_q) && (pos_y_q == target_y_q);
	assign visible = ({1'b0, pos_x_q} < (COORD_W+1)'(SCREEN_WIDTH)) &&
	                 ({1'b0, pos_y_q} < (COORD_W+1)'(SCREEN_HEIGHT));

	always_comb begin
		e2         = $signed({error_term_q, 1'b0});
		neg_span_y = -$signed({3'b000, span_y_q});
		pos_span_x = $signed({3'b000, span_x_q});
		take_x     = (e2 >= neg_span_y);
		take_y     = (e2 <= pos_span_x);
		err_next   = $signed({error_term_q[ERR_W-1], error_term_q});
		if (take_x) begin
			err_next = err_next + neg_span_y;
		end
		if (take_y) begin
			err_next = err_next + pos_span_x;
		end
		next_x = step_x_neg_q ? (pos_x_q - 1'b1) : (pos_x_q + 1'b1);
		next_y = step_y_neg_q ? (pos_y_q - 1'b1) : (pos_y_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			target_x_q   <= '0;
			target_y_q   <= '0;
			span_x_q     <= '0;
			span_y_q     <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			error_term_q <= '0;
			line_color_q <= '0;
			active_q     <= 1'b0;
		end else if (head_valid && is_load) begin
			pos_x_q      <= head_item.start_x;
			pos_y_q      <= head_item.start_y;
			target_x_q   <= head_item.end_x;
			target_y_q   <= head_item.end_y;
			span_x_q     <= head_item.span_x;
			span_y_q     <= head_item.span_y;
			step_x_neg_q <= head_item.step_x_neg;
			step_y_neg_q <= head_item.step_y_neg;
			error_term_q <= head_item.error_term;
			line_color_q <= head_item.color;
			active_q     <= 1'b1;
		end else if (emit) begin
			if (at_end) begin
				active_q <= 1'b0;
			end else begin
				error_term_q <= err_next[ERR_W-1:0];
				if (take_x) begin
					pos_x_q <= next_x;
				end
				if (take_y) begin
					pos_y_q <= next_y;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q    <= {line_color_q, pos_y_q, pos_x_q};
			out_visible_q <= visible;
			out_last_q    <= at_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_visible_q;
	assign m_axis_tlast  = out_last_q;

endmodule
